>>> hdl/lzwc_pkg.sv
// Package for the LZW compressor: widths, dictionary size, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
package lzwc_pkg;

  localparam int CODE_W       = 12;
  localparam int BYTE_W       = 8;
  localparam int DICT_ENTRIES = 4096;
  localparam int CODE_SPACE   = 4096;
  localparam int CODE_LIMIT   = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;
  localparam int HASH_W       = $clog2(CODE_LIMIT);
  localparam int FREE_W       = CODE_W + 1;
  localparam logic [FREE_W-1:0] FIRST_LEARNED = FREE_W'(256);
  localparam logic [FREE_W-1:0] FREE_LIMIT    = FREE_W'(CODE_LIMIT);
  localparam int PAIR_W       = CODE_W + BYTE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_EMIT,
    ST_FINAL
  } lzwc_state_t;

  typedef struct packed {
    logic load;       // capture the input item
    logic start_scan; // reset scan pointer to first learned code
    logic step_scan;  // advance scan pointer
    logic take_hit;   // prefix becomes the matching code
    logic miss;       // emit prefix, learn pair, prefix becomes the byte
    logic finish;     // emit final code and clear the message state
  } lzwc_cmd_t;

  typedef struct packed {
    logic prefix_valid;
    logic last_byte;
    logic scan_done;  // no more learned codes to compare
    logic hit;        // registered read data equals the pair
  } lzwc_sts_t;

endpackage

>>> hdl/lzwc_if.sv
// Valid/ready stream interfaces for the LZW compressor channels.
// Depends on lzwc_pkg.
interface lzwc_in_if import lzwc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_message;
  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, end_of_message, output ready);
endinterface

interface lzwc_out_if import lzwc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] out_code;
  logic              last_code;
  modport source (output valid, out_code, last_code, input ready);
  modport sink (input valid, out_code, last_code, output ready);
endinterface

>>> hdl/lzwc_datapath.sv
// Datapath of the LZW compressor: prefix registers, dictionary memory with a
// registered read port, scan pointer and free-code counter.
// Depends on lzwc_pkg.
module lzwc_datapath import lzwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  lzwc_cmd_t         cmd,
  output lzwc_sts_t         sts,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  output logic [CODE_W-1:0] out_code,
  output logic              out_last
);

  logic [PAIR_W-1:0] dict_mem [CODE_LIMIT];
  logic [PAIR_W-1:0] rd_data_r;
  logic [CODE_W-1:0] prefix_r, prefix_nxt;
  logic              pvalid_r, pvalid_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [FREE_W-1:0] scan_r, scan_nxt;
  logic [FREE_W-1:0] hit_code_r;
  logic [BYTE_W-1:0] byte_r;
  logic              last_r;
  logic [PAIR_W-1:0] pair;

  assign pair = {prefix_r, byte_r};

  // One entry is read per cycle; the code read is kept with its data.
  always_ff @(posedge clk) begin
    if (cmd.miss && free_r < FREE_LIMIT) begin
      dict_mem[free_r[HASH_W-1:0]] <= pair;
    end
    rd_data_r  <= dict_mem[scan_r[HASH_W-1:0]];
    hit_code_r <= scan_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
    if (cmd.miss) begin
      out_code <= prefix_r;
      out_last <= 1'b0;
    end else if (cmd.finish) begin
      out_code <= prefix_r;
      out_last <= 1'b1;
    end
  end

  always_comb begin
    prefix_nxt = prefix_r;
    pvalid_nxt = pvalid_r;
    free_nxt   = free_r;
    scan_nxt   = scan_r;
    if (cmd.start_scan) scan_nxt = FIRST_LEARNED;
    if (cmd.step_scan)  scan_nxt = scan_r + FREE_W'(1);
    if (cmd.load && !pvalid_r) begin
      prefix_nxt = CODE_W'(in_byte);
      pvalid_nxt = 1'b1;
    end
    if (cmd.take_hit) prefix_nxt = hit_code_r[CODE_W-1:0];
    if (cmd.miss) begin
      prefix_nxt = CODE_W'(byte_r);
      if (free_r < FREE_LIMIT) free_nxt = free_r + FREE_W'(1);
    end
    if (cmd.finish) begin
      prefix_nxt = '0;
      pvalid_nxt = 1'b0;
      free_nxt   = FIRST_LEARNED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
      pvalid_r <= 1'b0;
      free_r   <= FIRST_LEARNED;
      scan_r   <= FIRST_LEARNED;
    end else begin
      prefix_r <= prefix_nxt;
      pvalid_r <= pvalid_nxt;
      free_r   <= free_nxt;
      scan_r   <= scan_nxt;
    end
  end

  assign sts.prefix_valid = pvalid_r;
  assign sts.last_byte    = last_r;
  assign sts.scan_done    = (scan_r >= free_r);
  assign sts.hit          = (rd_data_r == pair);

endmodule

>>> hdl/lzwc_ctrl.sv
// Controller of the LZW compressor: sequences the dictionary scan and the
// output handshake. Depends on lzwc_pkg.
module lzwc_ctrl import lzwc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lzwc_sts_t sts,
  output lzwc_cmd_t cmd
);

  lzwc_state_t state_r, state_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic        accept;
  // Set while the read issued last cycle is for a live code.
  logic        rd_live_r, rd_live_nxt;

  assign accept    = in_valid && in_ready;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        // The first byte of a message becomes the prefix without a scan.
        if (accept) state_nxt = sts.prefix_valid ? ST_PROBE : ST_FINAL;
      end
      ST_PROBE: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!sts.prefix_valid) begin
          state_nxt = ST_FINAL;
        end else if (rd_live_r && sts.hit) begin
          state_nxt = ST_FINAL;
        end else if (!rd_live_r) begin
          if (!ovalid_r || out_ready) state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!sts.last_byte) state_nxt = ST_IDLE;
        else if (!ovalid_r || out_ready) state_nxt = ST_IDLE;
      end
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    ovalid_nxt  = ovalid_r && !out_ready;
    rd_live_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.load       = 1'b1;
          cmd.start_scan = 1'b1;
        end
      end
      ST_PROBE: begin
        rd_live_nxt   = !sts.scan_done;
        cmd.step_scan = !sts.scan_done;
      end
      ST_CHECK: begin
        if (sts.prefix_valid) begin
          if (rd_live_r && sts.hit) begin
            cmd.take_hit = 1'b1;
          end else if (rd_live_r) begin
            rd_live_nxt   = !sts.scan_done;
            cmd.step_scan = !sts.scan_done;
          end else if (!ovalid_r || out_ready) begin
            cmd.miss   = 1'b1;
            ovalid_nxt = 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (sts.last_byte && (!ovalid_r || out_ready)) begin
          cmd.finish = 1'b1;
          ovalid_nxt = 1'b1;
        end
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ovalid_r  <= 1'b0;
      rd_live_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ovalid_r  <= ovalid_nxt;
      rd_live_r <= rd_live_nxt;
    end
  end

endmodule

>>> hdl/lzw_compressor.sv
// LZW compressor with 12-bit codes. Each byte is matched against the learned
// dictionary by a linear scan of one entry per cycle through a memory with
// one write port and a registered read port. The first byte of a message is
// not scanned, a hit ends the scan at the matching learned code, and a byte
// whose pair is not found is compared with every learned code. An item that
// emits a code also waits while the previous code is still held in the output
// register. The last byte of a message yields the final code, marked last,
// and clears the dictionary count.
// Depends on lzwc_pkg, lzwc_if, lzwc_ctrl and lzwc_datapath.
module lzw_compressor import lzwc_pkg::*; (
  input logic clk,
  input logic rst_n,
  lzwc_in_if.sink    in_ch,
  lzwc_out_if.source out_ch
);

  lzwc_cmd_t cmd;
  lzwc_sts_t sts;

  lzwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lzwc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_byte  (in_ch.data_byte),
    .in_last  (in_ch.end_of_message),
    .out_code (out_ch.out_code),
    .out_last (out_ch.last_code)
  );

endmodule

>>> hdl/lzwc_checker.sv
// Port-level checker for the LZW compressor, bound to the top level.
// Depends on lzwc_pkg.
module lzwc_checker import lzwc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CODE_W-1:0] out_code,
  input logic              last_code
);

  // A pending result is never dropped.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code))
    else $error("stalled result changed");

  // Input is never taken twice in consecutive cycles: the controller leaves idle after each item.
  a_no_b2b: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // The last-code flag of a stalled result does not change.
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(last_code))
    else $error("stalled last flag changed");

endmodule

bind lzw_compressor lzwc_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_code  (out_ch.out_code),
  .last_code (out_ch.last_code)
);

>>> test/lzw_compressor_checker.sv
`timescale 1ns / 1ps
// Checker for the LZW compressor: watches both stream channels, predicts the
// emitted codes from accepted bytes and compares them. Depends on lzwc_pkg, lzwc_if.
module lzw_compressor_checker import lzwc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_eom,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [11:0] out_code,
  input  logic        out_last,
  output int          fail_count,
  output int          codes_pending
);

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } code_item_t;

  code_item_t        expected_codes[$];
  logic [PAIR_W-1:0] learned_pairs[CODE_LIMIT];
  logic [CODE_W-1:0] cur_prefix;
  logic              have_prefix;
  int unsigned       free_code;

  initial begin
    fail_count = 0;
    have_prefix = 1'b0;
    cur_prefix = '0;
    free_code = 256;
  end

  assign codes_pending = expected_codes.size();

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // Compress one byte into zero, one or two expected codes.
  task automatic compress_byte(input logic [7:0] b, input logic eom);
    logic [PAIR_W-1:0] pair;
    int unsigned hit;
    code_item_t e;
    hit = 0;
    if (!have_prefix) begin
      cur_prefix = CODE_W'(b);
      have_prefix = 1'b1;
    end else begin
      pair = {cur_prefix, b};
      for (int unsigned c = 256; c < free_code; c++)
        if (learned_pairs[c] == pair) begin
          hit = c;
          break;
        end
      if (hit != 0) begin
        cur_prefix = CODE_W'(hit);
      end else begin
        e.code = cur_prefix;
        e.last = 1'b0;
        expected_codes = {expected_codes, e};
        if (free_code < CODE_LIMIT) begin
          learned_pairs[free_code] = pair;
          free_code++;
        end
        cur_prefix = CODE_W'(b);
      end
    end
    if (eom) begin
      e.code = cur_prefix;
      e.last = 1'b1;
      expected_codes = {expected_codes, e};
      cur_prefix = '0;
      have_prefix = 1'b0;
      free_code = 256;
    end
  endtask

  always @(posedge clk) begin
    code_item_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_codes.size() == 0) begin
          report($sformatf("unexpected code %0d last %0b", out_code, out_last));
        end else begin
          e = expected_codes.pop_front();
          if (out_code !== e.code)
            report($sformatf("code %0d, expected %0d", out_code, e.code));
          if (out_last !== e.last)
            report($sformatf("last %0b, expected %0b (code %0d)", out_last, e.last, e.code));
        end
      end
      if (in_valid && in_ready) compress_byte(in_byte, in_eom);
    end
  end

endmodule

>>> test/lzw_compressor_tb.sv
`timescale 1ns / 1ps
// Testbench top for the LZW compressor: drives messages of bytes with random
// gaps and output stalls, and gives the verdict. Depends on lzwc_pkg, lzwc_if,
// lzw_compressor and lzw_compressor_checker.
module lzw_compressor_tb import lzwc_pkg::*; ();

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   codes_pending;
  logic steady_mode = 1'b0;
  logic hold_off = 1'b0;
  logic stim_done = 1'b0;

  lzwc_in_if  in_ch ();
  lzwc_out_if out_ch ();

  lzw_compressor dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  lzw_compressor_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.data_byte), .in_eom(in_ch.end_of_message),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_code(out_ch.out_code), .out_last(out_ch.last_code),
    .fail_count(fail_count), .codes_pending(codes_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_message = 1'b0;
  end

  // The receiver stalls at random with a probability of 37 in 100, never during steady mode.
  always @(posedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else if (steady_mode) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(99) >= 37);
  end

  // Offer one byte; the transaction completes when ready is seen high.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    while (!steady_mode && $urandom_range(99) < 37) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_message(input int len, input int alphabet);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(alphabet - 1)), i == len - 1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: one-byte messages at both extremes, repeats that extend prefixes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    for (int i = 0; i < 12; i++) send_byte(8'h41, i == 11);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // Long receiver hold-off while the sender keeps offering bytes.
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      send_message(20, 3);
    join
    // Random messages; a stretch without any idling in the middle.
    for (int m = 0; m < 20; m++) begin
      steady_mode <= (m >= 8 && m < 15);
      case ($urandom_range(3))
        0: send_message($urandom_range(1, 4), 256);
        1: send_message($urandom_range(5, 20), 4);
        2: send_message($urandom_range(5, 20), 256);
        default: send_message($urandom_range(10, 25), 2);
      endcase
    end
    steady_mode <= 1'b0;
    // One long message that grows the dictionary; few symbols keep scans short.
    send_message(250, 2);
    in_ch.valid <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    wait (stim_done);
    while (codes_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #60ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
